/* rtl/euler_yxz_view_matrix_defines.svh */
// assertion macros for the view matrix block
`ifndef EULER_YXZ_VIEW_MATRIX_DEFINES_SVH
`define EULER_YXZ_VIEW_MATRIX_DEFINES_SVH

// implication checked on every rising clock edge outside reset
`define EVM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// plain condition checked on every rising clock edge outside reset
`define EVM_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error(msg);

`endif

/* rtl/evm_pkg.sv */
package evm_pkg;

  localparam int POS_W   = 32;
  localparam int ANG_W   = 16;
  localparam int B_W     = 16;
  localparam int ITERS   = 30;
  localparam int IDX_W   = 5;
  localparam int Z_W     = 35;
  localparam int XY_W    = 33;
  localparam int ANG_SH  = 33 - ANG_W;
  localparam int PROD_W  = 30;
  localparam int TRI_W   = 48;
  localparam int DOT_W   = POS_W + B_W;
  localparam int SUM_W   = DOT_W + 2;
  localparam int LATENCY = ITERS + 6;

  localparam logic signed [Z_W-1:0]  PI_Q30      = Z_W'(64'sd3373259426);
  localparam logic signed [Z_W-1:0]  HALF_PI_Q30 = Z_W'(64'sd1686629713);
  localparam logic signed [XY_W-1:0] CORDIC_GAIN = XY_W'(64'sd652032874);
  localparam logic signed [B_W-1:0]  BASIS_MAX   = B_W'(16384);

  typedef struct packed {
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
    logic signed [ANG_W-1:0] pitch_angle;
    logic signed [ANG_W-1:0] yaw_angle;
    logic signed [ANG_W-1:0] roll_angle;
  } evm_in_t;

  typedef struct packed {
    logic signed [B_W-1:0]   right_x;
    logic signed [B_W-1:0]   right_y;
    logic signed [B_W-1:0]   right_z;
    logic signed [B_W-1:0]   up_x;
    logic signed [B_W-1:0]   up_y;
    logic signed [B_W-1:0]   up_z;
    logic signed [B_W-1:0]   fwd_x;
    logic signed [B_W-1:0]   fwd_y;
    logic signed [B_W-1:0]   fwd_z;
    logic signed [POS_W-1:0] trans_u;
    logic signed [POS_W-1:0] trans_v;
    logic signed [POS_W-1:0] trans_w;
  } evm_out_t;

  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
    logic                   flip;
  } evm_rot_t;

  // index 0 pitch, 1 yaw, 2 roll
  typedef struct packed {
    evm_rot_t [2:0]          rot;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
  } evm_cell_t;

  typedef struct packed {
    logic signed [B_W-1:0]   b_x;
    logic signed [B_W-1:0]   b_y;
    logic signed [B_W-1:0]   b_z;
  } evm_vec_t;

  function automatic logic signed [Z_W-1:0] atan_f(input logic [IDX_W-1:0] i);
    logic signed [Z_W-1:0] r;
    case (i)
      5'd0:    r = Z_W'(843314856);
      5'd1:    r = Z_W'(497837829);
      5'd2:    r = Z_W'(263043836);
      5'd3:    r = Z_W'(133525158);
      5'd4:    r = Z_W'(67021686);
      5'd5:    r = Z_W'(33543515);
      5'd6:    r = Z_W'(16775850);
      5'd7:    r = Z_W'(8388437);
      5'd8:    r = Z_W'(4194282);
      5'd9:    r = Z_W'(2097149);
      5'd10:   r = Z_W'(1048575);
      5'd11:   r = Z_W'(524287);
      5'd12:   r = Z_W'(262143);
      5'd13:   r = Z_W'(131071);
      5'd14:   r = Z_W'(65535);
      5'd15:   r = Z_W'(32767);
      5'd16:   r = Z_W'(16383);
      5'd17:   r = Z_W'(8191);
      5'd18:   r = Z_W'(4095);
      5'd19:   r = Z_W'(2047);
      5'd20:   r = Z_W'(1023);
      5'd21:   r = Z_W'(511);
      5'd22:   r = Z_W'(255);
      5'd23:   r = Z_W'(127);
      5'd24:   r = Z_W'(63);
      5'd25:   r = Z_W'(31);
      5'd26:   r = Z_W'(15);
      5'd27:   r = Z_W'(7);
      5'd28:   r = Z_W'(3);
      5'd29:   r = Z_W'(1);
      default: r = '0;
    endcase
    return r;
  endfunction

  // clamp a wide value to +-1.0 in q2.14
  function automatic logic signed [B_W-1:0] clamp_b(input logic signed [TRI_W-1:0] v);
    logic signed [B_W-1:0] r;
    if (v > TRI_W'(BASIS_MAX)) begin
      r = BASIS_MAX;
    end else if (v < -TRI_W'(BASIS_MAX)) begin
      r = -BASIS_MAX;
    end else begin
      r = v[B_W-1:0];
    end
    return r;
  endfunction

  // q.30 to q2.14, round half up, then sign fold
  function automatic logic signed [B_W-1:0] round_sc(input logic signed [XY_W-1:0] v,
                                                      input logic flip);
    logic signed [TRI_W-1:0] t;
    logic signed [B_W-1:0]   c;
    t = (TRI_W'(v) + TRI_W'(32768)) >>> 16;
    c = clamp_b(t);
    return flip ? -c : c;
  endfunction

endpackage

/* rtl/euler_yxz_view_matrix.sv */
// euler yxz view matrix
// channels: an item (camera position and pitch, yaw, roll angles) enters on
// start_i/item_i and is taken at a rising edge where start_i is high and
// busy_o is low. busy_o is high only while reset is asserted, so one item
// may be taken every cycle.
// each item yields exactly one result on res_o, marked by done_o for a
// single cycle, once it has passed in order through angle folding, 30
// cordic cells (one micro-rotation each, all three angles side by side),
// rounding of sine and cosine, the pair products, the basis sums, the
// translation products, and the output register.
// throughput is one item per cycle, set by the cell chain handing its
// contents on every clock.
// the receiver cannot hold results off; there is no stall path.
// reset clears the valid bits of every stage, so nothing emerges from items
// that were in flight when reset arrived.
module euler_yxz_view_matrix (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  evm_pkg::evm_in_t   item_i,
  output logic               busy_o,
  output logic               done_o,
  output evm_pkg::evm_out_t  res_o
);
  import evm_pkg::*;

  // folding stage
  logic      fold_valid_q;
  evm_cell_t fold_d, fold_q;
  logic signed [ANG_W-1:0] ang [3];
  logic signed [Z_W-1:0]   z0;

  // cell chain taps
  logic      chain_valid [ITERS+1];
  evm_cell_t chain_cell  [ITERS+1];

  // basis to translation
  logic     basis_valid;
  evm_vec_t u_b, v_b, w_b;
  logic signed [POS_W-1:0] px_b, py_b, pz_b;

  assign busy_o = ~rst_ni;

  always_comb begin
    ang[0] = item_i.pitch_angle;
    ang[1] = item_i.yaw_angle;
    ang[2] = item_i.roll_angle;
    fold_d.pos_x = item_i.pos_x;
    fold_d.pos_y = item_i.pos_y;
    fold_d.pos_z = item_i.pos_z;
    for (int k = 0; k < 3; k++) begin
      // angle to q.30 radians, then folded once by pi into +-pi/2
      z0 = Z_W'(ang[k]) <<< ANG_SH;
      fold_d.rot[k].x = CORDIC_GAIN;
      fold_d.rot[k].y = '0;
      if (z0 > HALF_PI_Q30) begin
        fold_d.rot[k].z    = z0 - PI_Q30;
        fold_d.rot[k].flip = 1'b1;
      end else if (z0 < -HALF_PI_Q30) begin
        fold_d.rot[k].z    = z0 + PI_Q30;
        fold_d.rot[k].flip = 1'b1;
      end else begin
        fold_d.rot[k].z    = z0;
        fold_d.rot[k].flip = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fold_valid_q <= 1'b0;
    end else begin
      fold_valid_q <= start_i & ~busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    fold_q <= fold_d;
  end

  assign chain_valid[0] = fold_valid_q;
  assign chain_cell[0]  = fold_q;

  // one cell per cordic iteration, each with its own shift and arctangent
  for (genvar g = 0; g < ITERS; g++) begin : g_cell
    evm_cordic_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .iter_i  (IDX_W'(g)),
      .valid_i (chain_valid[g]),
      .cell_i  (chain_cell[g]),
      .valid_o (chain_valid[g+1]),
      .cell_o  (chain_cell[g+1])
    );
  end

  evm_basis u_basis (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (chain_valid[ITERS]),
    .cell_i  (chain_cell[ITERS]),
    .valid_o (basis_valid),
    .u_o     (u_b),
    .v_o     (v_b),
    .w_o     (w_b),
    .pos_x_o (px_b),
    .pos_y_o (py_b),
    .pos_z_o (pz_b)
  );

  evm_trans u_trans (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (basis_valid),
    .u_i     (u_b),
    .v_i     (v_b),
    .w_i     (w_b),
    .pos_x_i (px_b),
    .pos_y_i (py_b),
    .pos_z_i (pz_b),
    .valid_o (done_o),
    .res_o   (res_o)
  );

endmodule

/* rtl/evm_cordic_cell.sv */
module evm_cordic_cell (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [evm_pkg::IDX_W-1:0] iter_i,
  input  logic                     valid_i,
  input  evm_pkg::evm_cell_t       cell_i,
  output logic                     valid_o,
  output evm_pkg::evm_cell_t       cell_o
);
  import evm_pkg::*;

  logic      valid_q;
  evm_cell_t cell_d, cell_q;
  logic signed [XY_W-1:0] dx, dy;
  logic signed [Z_W-1:0]  at;

  // one micro-rotation for all three angles
  always_comb begin
    cell_d = cell_i;
    at     = atan_f(iter_i);
    for (int k = 0; k < 3; k++) begin
      dx = cell_i.rot[k].y >>> iter_i;
      dy = cell_i.rot[k].x >>> iter_i;
      if (!cell_i.rot[k].z[Z_W-1]) begin
        cell_d.rot[k].x = cell_i.rot[k].x - dx;
        cell_d.rot[k].y = cell_i.rot[k].y + dy;
        cell_d.rot[k].z = cell_i.rot[k].z - at;
      end else begin
        cell_d.rot[k].x = cell_i.rot[k].x + dx;
        cell_d.rot[k].y = cell_i.rot[k].y - dy;
        cell_d.rot[k].z = cell_i.rot[k].z + at;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    cell_q <= cell_d;
  end

  assign valid_o = valid_q;
  assign cell_o  = cell_q;

endmodule

/* rtl/evm_basis.sv */
module evm_basis (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  input  evm_pkg::evm_cell_t            cell_i,
  output logic                          valid_o,
  output evm_pkg::evm_vec_t             u_o,
  output evm_pkg::evm_vec_t             v_o,
  output evm_pkg::evm_vec_t             w_o,
  output logic signed [evm_pkg::POS_W-1:0] pos_x_o,
  output logic signed [evm_pkg::POS_W-1:0] pos_y_o,
  output logic signed [evm_pkg::POS_W-1:0] pos_z_o
);
  import evm_pkg::*;

  logic [2:0] valid_q;

  // stage r: rounded sines and cosines
  logic signed [B_W-1:0] s1_q, c1_q, s2_q, c2_q, s3_q, c3_q;
  logic signed [POS_W-1:0] px_r_q, py_r_q, pz_r_q;

  // stage a: pair products
  logic signed [PROD_W-1:0] c1c3_q, s1s2_q, c1s2_q, c3s1_q, c1s3_q, s1s3_q;
  logic signed [PROD_W-1:0] c2s3_q, c2c3_q, c2s1_q, c1c2_q;
  logic signed [B_W-1:0]    s2_a_q, s3_a_q, c3_a_q;
  logic signed [POS_W-1:0]  px_a_q, py_a_q, pz_a_q;

  // stage b: basis
  evm_vec_t u_q, v_q, w_q;
  logic signed [POS_W-1:0] px_b_q, py_b_q, pz_b_q;

  localparam int Q42_SH = 28;
  localparam int Q28_SH = 14;

  function automatic logic signed [B_W-1:0] q42(input logic signed [TRI_W-1:0] v);
    return clamp_b((v + (TRI_W'(1) <<< (Q42_SH - 1))) >>> Q42_SH);
  endfunction

  function automatic logic signed [B_W-1:0] q28(input logic signed [PROD_W-1:0] v);
    logic signed [TRI_W-1:0] t;
    t = (TRI_W'(v) + (TRI_W'(1) <<< (Q28_SH - 1))) >>> Q28_SH;
    return clamp_b(t);
  endfunction

  function automatic logic signed [TRI_W-1:0] shq(input logic signed [PROD_W-1:0] v);
    return TRI_W'(v) <<< Q28_SH;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    c2_q   <= round_sc(cell_i.rot[0].x, cell_i.rot[0].flip);
    s2_q   <= round_sc(cell_i.rot[0].y, cell_i.rot[0].flip);
    c1_q   <= round_sc(cell_i.rot[1].x, cell_i.rot[1].flip);
    s1_q   <= round_sc(cell_i.rot[1].y, cell_i.rot[1].flip);
    c3_q   <= round_sc(cell_i.rot[2].x, cell_i.rot[2].flip);
    s3_q   <= round_sc(cell_i.rot[2].y, cell_i.rot[2].flip);
    px_r_q <= cell_i.pos_x;
    py_r_q <= cell_i.pos_y;
    pz_r_q <= cell_i.pos_z;

    c1c3_q <= PROD_W'(c1_q * c3_q);
    s1s2_q <= PROD_W'(s1_q * s2_q);
    c1s2_q <= PROD_W'(c1_q * s2_q);
    c3s1_q <= PROD_W'(c3_q * s1_q);
    c1s3_q <= PROD_W'(c1_q * s3_q);
    s1s3_q <= PROD_W'(s1_q * s3_q);
    c2s3_q <= PROD_W'(c2_q * s3_q);
    c2c3_q <= PROD_W'(c2_q * c3_q);
    c2s1_q <= PROD_W'(c2_q * s1_q);
    c1c2_q <= PROD_W'(c1_q * c2_q);
    s2_a_q <= s2_q;
    s3_a_q <= s3_q;
    c3_a_q <= c3_q;
    px_a_q <= px_r_q;
    py_a_q <= py_r_q;
    pz_a_q <= pz_r_q;

    u_q.b_x <= q42(shq(c1c3_q) + TRI_W'(s1s2_q * s3_a_q));
    u_q.b_y <= q28(c2s3_q);
    u_q.b_z <= q42(TRI_W'(c1s2_q * s3_a_q) - shq(c3s1_q));
    v_q.b_x <= q42(TRI_W'(c3s1_q * s2_a_q) - shq(c1s3_q));
    v_q.b_y <= q28(c2c3_q);
    v_q.b_z <= q42(TRI_W'(c1s2_q * c3_a_q) + shq(s1s3_q));
    w_q.b_x <= q28(c2s1_q);
    w_q.b_y <= -s2_a_q;
    w_q.b_z <= q28(c1c2_q);
    px_b_q  <= px_a_q;
    py_b_q  <= py_a_q;
    pz_b_q  <= pz_a_q;
  end

  assign valid_o = valid_q[2];
  assign u_o     = u_q;
  assign v_o     = v_q;
  assign w_o     = w_q;
  assign pos_x_o = px_b_q;
  assign pos_y_o = py_b_q;
  assign pos_z_o = pz_b_q;

endmodule

/* rtl/evm_trans.sv */
module evm_trans (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             valid_i,
  input  evm_pkg::evm_vec_t                u_i,
  input  evm_pkg::evm_vec_t                v_i,
  input  evm_pkg::evm_vec_t                w_i,
  input  logic signed [evm_pkg::POS_W-1:0] pos_x_i,
  input  logic signed [evm_pkg::POS_W-1:0] pos_y_i,
  input  logic signed [evm_pkg::POS_W-1:0] pos_z_i,
  output logic                             valid_o,
  output evm_pkg::evm_out_t                res_o
);
  import evm_pkg::*;

  logic [1:0] valid_q;
  evm_vec_t u_q, v_q, w_q;
  logic signed [DOT_W-1:0] pu_q [3];
  logic signed [DOT_W-1:0] pv_q [3];
  logic signed [DOT_W-1:0] pw_q [3];
  evm_out_t res_q;

  function automatic logic signed [POS_W-1:0] neg_sat(input logic signed [DOT_W-1:0] a,
                                                       input logic signed [DOT_W-1:0] b,
                                                       input logic signed [DOT_W-1:0] c);
    logic signed [SUM_W-1:0] s;
    logic signed [SUM_W-1:0] r;
    logic signed [SUM_W-1:0] lim;
    s   = SUM_W'(a) + SUM_W'(b) + SUM_W'(c);
    r   = -((s + SUM_W'(8192)) >>> 14);
    lim = (SUM_W'(1) <<< (POS_W - 1)) - SUM_W'(1);
    if (r > lim) begin
      return lim[POS_W-1:0];
    end else if (r < -lim - SUM_W'(1)) begin
      return POS_W'(-lim - SUM_W'(1));
    end
    return r[POS_W-1:0];
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    u_q      <= u_i;
    v_q      <= v_i;
    w_q      <= w_i;
    pu_q[0]  <= DOT_W'(u_i.b_x * pos_x_i);
    pu_q[1]  <= DOT_W'(u_i.b_y * pos_y_i);
    pu_q[2]  <= DOT_W'(u_i.b_z * pos_z_i);
    pv_q[0]  <= DOT_W'(v_i.b_x * pos_x_i);
    pv_q[1]  <= DOT_W'(v_i.b_y * pos_y_i);
    pv_q[2]  <= DOT_W'(v_i.b_z * pos_z_i);
    pw_q[0]  <= DOT_W'(w_i.b_x * pos_x_i);
    pw_q[1]  <= DOT_W'(w_i.b_y * pos_y_i);
    pw_q[2]  <= DOT_W'(w_i.b_z * pos_z_i);

    res_q.right_x <= u_q.b_x;
    res_q.right_y <= u_q.b_y;
    res_q.right_z <= u_q.b_z;
    res_q.up_x    <= v_q.b_x;
    res_q.up_y    <= v_q.b_y;
    res_q.up_z    <= v_q.b_z;
    res_q.fwd_x   <= w_q.b_x;
    res_q.fwd_y   <= w_q.b_y;
    res_q.fwd_z   <= w_q.b_z;
    res_q.trans_u <= neg_sat(pu_q[0], pu_q[1], pu_q[2]);
    res_q.trans_v <= neg_sat(pv_q[0], pv_q[1], pv_q[2]);
    res_q.trans_w <= neg_sat(pw_q[0], pw_q[1], pw_q[2]);
  end

  assign valid_o = valid_q[1];
  assign res_o   = res_q;

endmodule

/* rtl/evm_checker.sv */
`include "euler_yxz_view_matrix_defines.svh"

module evm_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start_i,
  input logic              busy_o,
  input logic              done_o,
  input evm_pkg::evm_out_t res_o
);
  import evm_pkg::*;

  // every taken item gives exactly one result a fixed time later
  `EVM_ASSERT_ALWAYS(a_latency, done_o == $past(start_i && !busy_o, LATENCY), "result strobe out of step with taken items")

  // the fwd_y and up_y basis entries stay within +-1.0
  `EVM_ASSERT_IMP(a_fwd_y_range, done_o, res_o.fwd_y <= BASIS_MAX && res_o.fwd_y >= -BASIS_MAX, "fwd_y beyond unit range")

  `EVM_ASSERT_IMP(a_up_y_range, done_o, res_o.up_y <= BASIS_MAX && res_o.up_y >= -BASIS_MAX, "up_y beyond unit range")

endmodule

bind euler_yxz_view_matrix evm_checker u_evm_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start_i (start_i),
  .busy_o  (busy_o),
  .done_o  (done_o),
  .res_o   (res_o)
);

/* sim/evm_checker.sv */
`timescale 1ns / 1ps

module evm_scoreboard (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              busy_i,
  input  evm_pkg::evm_in_t  item_i,
  input  logic              done_i,
  input  evm_pkg::evm_out_t res_i,
  output int                fail_count_o,
  output int                pending_o
);
  import evm_pkg::*;

  evm_out_t matrix_q[$];
  int       mismatches;

  localparam longint PI_C   = 64'sd3373259426;
  localparam longint HPI_C  = 64'sd1686629713;
  localparam longint GAIN_C = 64'sd652032874;
  localparam longint ONE_B  = 64'sd16384;

  longint atan_tab [30] = '{
    843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
    16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143, 131071,
    65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255, 127, 63, 31,
    15, 7, 3, 1};

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // cordic rotation mode, outputs rounded to q2.14
  function automatic void angle_sincos(input longint code, output longint s,
                                       output longint c);
    longint z, x, y, dx, dy;
    bit fold;
    z = code * (64'sd1 <<< ANG_SH);
    x = GAIN_C;
    y = 0;
    fold = 0;
    if (z > HPI_C) begin
      z -= PI_C; fold = 1;
    end else if (z < -HPI_C) begin
      z += PI_C; fold = 1;
    end
    for (int i = 0; i < 30; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_tab[i];
      end else begin
        x += dx; y -= dy; z += atan_tab[i];
      end
    end
    x = clip((x + (64'sd1 <<< 15)) >>> 16, -ONE_B, ONE_B);
    y = clip((y + (64'sd1 <<< 15)) >>> 16, -ONE_B, ONE_B);
    c = fold ? -x : x;
    s = fold ? -y : y;
  endfunction

  function automatic longint pair_round(longint v);
    return clip((v + (64'sd1 <<< 13)) >>> 14, -ONE_B, ONE_B);
  endfunction

  function automatic longint triple_round(longint v);
    return clip((v + (64'sd1 <<< 27)) >>> 28, -ONE_B, ONE_B);
  endfunction

  function automatic longint neg_proj(longint bx, longint by, longint bz, longint px,
                                      longint py, longint pz);
    longint lim, r;
    lim = (64'sd1 <<< (POS_W - 1)) - 1;
    r = -((bx * px + by * py + bz * pz + (64'sd1 <<< 13)) >>> 14);
    return clip(r, -lim - 1, lim);
  endfunction

  function automatic evm_out_t view_matrix(evm_in_t it);
    evm_out_t o;
    longint s1, c1, s2, c2, s3, c3, px, py, pz;
    longint ux, uy, uz, vx, vy, vz, wx, wy, wz;
    px = longint'(it.pos_x);
    py = longint'(it.pos_y);
    pz = longint'(it.pos_z);
    angle_sincos(longint'(it.pitch_angle), s2, c2);
    angle_sincos(longint'(it.yaw_angle), s1, c1);
    angle_sincos(longint'(it.roll_angle), s3, c3);
    ux = triple_round(c1 * c3 * ONE_B + s1 * s2 * s3);
    uy = pair_round(c2 * s3);
    uz = triple_round(c1 * s2 * s3 - c3 * s1 * ONE_B);
    vx = triple_round(c3 * s1 * s2 - c1 * s3 * ONE_B);
    vy = pair_round(c2 * c3);
    vz = triple_round(c1 * c3 * s2 + s1 * s3 * ONE_B);
    wx = pair_round(c2 * s1);
    wy = -s2;
    wz = pair_round(c1 * c2);
    o.right_x = B_W'(ux); o.right_y = B_W'(uy); o.right_z = B_W'(uz);
    o.up_x = B_W'(vx); o.up_y = B_W'(vy); o.up_z = B_W'(vz);
    o.fwd_x = B_W'(wx); o.fwd_y = B_W'(wy); o.fwd_z = B_W'(wz);
    o.trans_u = POS_W'(neg_proj(ux, uy, uz, px, py, pz));
    o.trans_v = POS_W'(neg_proj(vx, vy, vz, px, py, pz));
    o.trans_w = POS_W'(neg_proj(wx, wy, wz, px, py, pz));
    return o;
  endfunction

  task automatic report(string f, longint e, longint a);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch %s: expected %0d actual %0d", f, e, a);
  endtask

  always @(posedge clk_i) begin
    evm_out_t e;
    if (rst_ni) begin
      if (start_i && !busy_i) matrix_q.push_back(view_matrix(item_i));
      if (done_i) begin
        if (matrix_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result, nothing pending");
        end else begin
          e = matrix_q.pop_front();
          if (res_i.right_x !== e.right_x) report("right_x", e.right_x, res_i.right_x);
          if (res_i.right_y !== e.right_y) report("right_y", e.right_y, res_i.right_y);
          if (res_i.right_z !== e.right_z) report("right_z", e.right_z, res_i.right_z);
          if (res_i.up_x !== e.up_x) report("up_x", e.up_x, res_i.up_x);
          if (res_i.up_y !== e.up_y) report("up_y", e.up_y, res_i.up_y);
          if (res_i.up_z !== e.up_z) report("up_z", e.up_z, res_i.up_z);
          if (res_i.fwd_x !== e.fwd_x) report("fwd_x", e.fwd_x, res_i.fwd_x);
          if (res_i.fwd_y !== e.fwd_y) report("fwd_y", e.fwd_y, res_i.fwd_y);
          if (res_i.fwd_z !== e.fwd_z) report("fwd_z", e.fwd_z, res_i.fwd_z);
          if (res_i.trans_u !== e.trans_u) report("trans_u", e.trans_u, res_i.trans_u);
          if (res_i.trans_v !== e.trans_v) report("trans_v", e.trans_v, res_i.trans_v);
          if (res_i.trans_w !== e.trans_w) report("trans_w", e.trans_w, res_i.trans_w);
        end
      end
    end
  end

  assign fail_count_o = mismatches;
  assign pending_o    = matrix_q.size();

  initial mismatches = 0;
endmodule

/* sim/tb_euler_yxz_view_matrix.sv */
`timescale 1ns / 1ps

module tb_euler_yxz_view_matrix;
  import evm_pkg::*;

  localparam int ANG_LIM = 25736;

  logic     clk_i;
  logic     rst_ni;
  logic     start_i;
  evm_in_t  item_i;
  logic     busy_o;
  logic     done_o;
  evm_out_t res_o;
  int       fail_count;
  int       pending;
  int       idle_pct;

  euler_yxz_view_matrix dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .item_i (item_i),
    .busy_o (busy_o),
    .done_o (done_o),
    .res_o  (res_o)
  );

  // watches both channels, keeps expected matrices, counts mismatches
  evm_scoreboard chk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_i      (busy_o),
    .item_i      (item_i),
    .done_i      (done_o),
    .res_i       (res_o),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  // 8 ns clock
  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  // random angle in the legal range, weighted toward +-pi and +-pi/2 for the fold logic
  function automatic logic signed [ANG_W-1:0] rand_angle();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return ANG_W'(ANG_LIM - $urandom_range(0, 20));
    if (sel == 1) return ANG_W'(-ANG_LIM + $urandom_range(0, 20));
    if (sel == 2) return ANG_W'($urandom_range(12860, 12880));  // near pi/2
    if (sel == 3) return ANG_W'(-$urandom_range(12860, 12880));
    return ANG_W'($urandom_range(0, 2 * ANG_LIM) - ANG_LIM);
  endfunction

  // random position: full width, small, or zero
  function automatic logic signed [POS_W-1:0] rand_pos();
    int sel;
    sel = $urandom_range(0, 5);
    if (sel == 0) return '0;
    if (sel == 1) return POS_W'($urandom_range(0, 1 << 20) - (1 << 19));
    if (sel == 2) return {1'b0, {(POS_W - 1){1'b1}}};
    if (sel == 3) return {1'b1, {(POS_W - 1){1'b0}}};
    return POS_W'($urandom);
  endfunction

  // hands one item over, with optional idle cycles before it, and holds it until taken
  task automatic send_item(input evm_in_t it);
    while ($urandom_range(0, 99) < idle_pct) begin
      start_i <= 1'b0;
      @(negedge clk_i);
    end
    item_i  <= it;
    start_i <= 1'b1;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic send_directed(input logic signed [POS_W-1:0] px, py, pz,
                               input logic signed [ANG_W-1:0] pa, ya, ra);
    evm_in_t it;
    it.pos_x = px; it.pos_y = py; it.pos_z = pz;
    it.pitch_angle = pa; it.yaw_angle = ya; it.roll_angle = ra;
    send_item(it);
  endtask

  initial begin
    evm_in_t it;
    logic signed [POS_W-1:0] pmax, pmin;
    pmax = {1'b0, {(POS_W - 1){1'b1}}};
    pmin = {1'b1, {(POS_W - 1){1'b0}}};
    rst_ni   = 1'b0;
    start_i  = 1'b0;
    item_i   = '0;
    idle_pct = 21;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: zero angles, angle extremes, fold boundary, translation saturation
    send_directed('0, '0, '0, '0, '0, '0);
    send_directed(32'sh00010000, 32'sh00020000, -32'sh00030000, '0, '0, '0);
    send_directed(pmax, pmax, pmax, ANG_W'(ANG_LIM), ANG_W'(ANG_LIM), ANG_W'(ANG_LIM));
    send_directed(pmin, pmin, pmin, -ANG_W'(ANG_LIM), -ANG_W'(ANG_LIM), -ANG_W'(ANG_LIM));
    send_directed(pmax, pmin, pmax, ANG_W'(12868), ANG_W'(12869), -ANG_W'(12868));
    send_directed(pmin, pmax, pmin, -ANG_W'(12869), ANG_W'(12867), ANG_W'(12870));
    send_directed(pmax, pmax, pmax, ANG_W'(25735), -ANG_W'(25735), '0);
    send_directed(pmin, pmin, pmin, '0, '0, '0);
    send_directed(pmax, pmax, pmax, '0, '0, '0);
    send_directed(pmax, '0, pmax, ANG_W'(6434), ANG_W'(6434), ANG_W'(6434));
    send_directed(-32'sd1, 32'sd1, -32'sd1, -ANG_W'(1), ANG_W'(1), -ANG_W'(1));
    send_directed(32'sh7FFF0000, 32'sh80010000, 32'sh12345678,
                  ANG_W'(25736), ANG_W'(-12868), ANG_W'(19302));
    send_directed(32'shFFFF_FFFF, 32'shAAAA_AAAA, 32'h5555_5555,
                  16'sh5555, -16'sh5555, 16'sh2AAA);

    // random: three idling phases
    for (int n = 0; n < 850; n++) begin
      if (n == 280) idle_pct = 59;
      if (n == 560) idle_pct = 0;
      it.pos_x       = rand_pos();
      it.pos_y       = rand_pos();
      it.pos_z       = rand_pos();
      it.pitch_angle = rand_angle();
      it.yaw_angle   = rand_angle();
      it.roll_angle  = rand_angle();
      send_item(it);
    end
    start_i <= 1'b0;

    // drain, then allow the pipeline latency for stray results
    while (pending != 0) @(posedge clk_i);
    repeat (LATENCY + 8) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // run limit
  initial begin
    #2000000;
    $display("RESULT: ERROR");
    $finish;
  end
endmodule
